### hdl/ent_pkg.sv
// Shared types and constants for the event note table.
package ent_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int MAX_RESULTS = 16;
    localparam int LIM_W       = 5;

    localparam logic [15:0] USER_FILTER  = 16'hFFF5;  // -11
    localparam int          USER_TRIG_BIT = 24;       // 0x01000000
    localparam logic [15:0] DEL_MASK_RST = 16'h0002;

    localparam logic [1:0] FN_CHANGE  = 2'd0;
    localparam logic [1:0] FN_FIRE    = 2'd1;
    localparam logic [1:0] FN_COLLECT = 2'd2;
    localparam logic [1:0] FN_UNUSED  = 2'd3;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam logic [0:0] REG_DEL_MASK = 1'b0;

    typedef struct packed {
        logic [63:0] ident;
        logic [15:0] filter;
        logic [15:0] flags;
        logic [31:0] fflags;
        logic [63:0] data;
        logic [63:0] user;
        logic        pend;
    } t_entry;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_SHIFT = 4'b0100,
        S_FIN   = 4'b1000
    } t_state;

endpackage

### hdl/event_note_table.sv
// Top level of the event note table: sequencer, entry table and output register.
//
// Usage:
//  - Input channel (i_in_valid / o_in_ready) carries one item: func selects
//    apply change, fire, or collect. Output channel (o_out_valid /
//    i_out_ready) carries the result items; the final one of each input has
//    o_last set.
//  - APB port holds delete_flag_mask at byte address 0; pready is always high.
//  - One shared read port walks the table one entry per cycle, except while a
//    collect waits on a full output register. A change walks up to the
//    matching entry; a delete then moves each later entry down one place to
//    close the gap. Fire walks every entry; collect walks until the table end
//    or the result limit.
//  - The block takes one item at a time: o_in_ready is high only in idle.
//  - Collect holds one found entry while looking ahead for the next, so the
//    last flag is known when each result leaves. Each result stalls the walk
//    when the output register is still full.
//  - A stalled receiver holds the output register; the final step waits for
//    it to free, so the input stays blocked until the result is taken.
//  - Reset clears the entry count, sequencer and output valid; entry
//    contents are not cleared, only entries below the count are ever read.
//  - delete_flag_mask returns to 2 at reset.
module event_note_table (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    input  logic         i_in_valid,
    output logic         o_in_ready,
    input  logic [1:0]   i_func,
    input  logic [63:0]  i_event_ident,
    input  logic         i_any_ident,
    input  logic signed [15:0] i_event_filter,
    input  logic [15:0]  i_event_flags,
    input  logic [31:0]  i_event_fflags,
    input  logic signed [63:0] i_event_data,
    input  logic [63:0]  i_user_word,
    input  logic [4:0]   i_max_out,
    output logic         o_out_valid,
    input  logic         i_out_ready,
    output logic [1:0]   o_status,
    output logic         o_event_valid,
    output logic [63:0]  o_out_ident,
    output logic signed [15:0] o_out_filter,
    output logic [15:0]  o_out_flags,
    output logic [31:0]  o_out_fflags,
    output logic signed [63:0] o_out_data,
    output logic [63:0]  o_out_user_word,
    output logic         o_last
);

    ent_pkg::t_entry r_tab [ent_pkg::TABLE_DEPTH];

    ent_pkg::t_state r_state, n_state;
    logic [15:0]                  r_del_mask;
    logic [ent_pkg::CNT_W-1:0]    r_cnt, n_cnt;
    logic [ent_pkg::CNT_W-1:0]    r_idx, n_idx;
    logic [ent_pkg::LIM_W-1:0]    r_n, n_n;
    logic [ent_pkg::LIM_W-1:0]    r_lim;
    logic [1:0]                   r_stat, n_stat;
    logic                         r_have, n_have;
    ent_pkg::t_entry              r_hold, n_hold;

    // latched input item
    logic [1:0]  r_func;
    logic [63:0] r_ident;
    logic        r_any;
    logic [15:0] r_filter;
    logic [15:0] r_flags;
    logic [31:0] r_fflags;
    logic [63:0] r_data;
    logic [63:0] r_user;

    // output register
    logic            r_ovalid;
    logic [1:0]      r_ostat;
    logic            r_olast;
    logic            r_oev;
    ent_pkg::t_entry r_oent;

    logic                      accept, out_free;
    logic [ent_pkg::CNT_W-1:0] rd_ptr;
    ent_pkg::t_entry           rd;
    logic                      wr_en;
    ent_pkg::t_entry           wr_ent;
    logic                      push, push_last, push_ev;
    logic [1:0]                push_stat;
    logic                      at_end, key_hit, fire_hit, is_del, is_trig;

    // APB
    assign pready = 1'b1;
    assign prdata = (paddr[2] == ent_pkg::REG_DEL_MASK) ? {16'h0, r_del_mask} : 32'h0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_del_mask <= ent_pkg::DEL_MASK_RST;
        end else if (psel && penable && pwrite && paddr[2] == ent_pkg::REG_DEL_MASK) begin
            r_del_mask <= pwdata[15:0];
        end
    end

    assign o_in_ready = (r_state == ent_pkg::S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign out_free   = !r_ovalid || i_out_ready;

    // single read port, shared by every walk
    assign rd_ptr = (r_state == ent_pkg::S_SHIFT) ? r_idx + ent_pkg::CNT_W'(1) : r_idx;
    assign rd     = r_tab[rd_ptr[ent_pkg::IDX_W-1:0]];

    assign at_end   = (r_idx == r_cnt);
    assign key_hit  = (rd.ident == r_ident) && (rd.filter == r_filter);
    assign fire_hit = ((r_filter == 16'h0) || (rd.filter == r_filter)) &&
                      (r_any || (rd.ident == r_ident));
    assign is_del   = (r_flags & r_del_mask) != 16'h0;
    assign is_trig  = (r_filter == ent_pkg::USER_FILTER) && r_fflags[ent_pkg::USER_TRIG_BIT];

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_idx     = r_idx;
        n_n       = r_n;
        n_stat    = r_stat;
        n_have    = r_have;
        n_hold    = r_hold;
        wr_en     = 1'b0;
        wr_ent    = rd;
        push      = 1'b0;
        push_last = 1'b0;
        push_ev   = r_have;
        push_stat = ent_pkg::ST_DONE;
        case (r_state)
            ent_pkg::S_IDLE: begin
                if (accept) begin
                    n_idx  = '0;
                    n_n    = '0;
                    n_have = 1'b0;
                    n_stat = (i_func == ent_pkg::FN_COLLECT) ? ent_pkg::ST_EMPTY
                                                             : ent_pkg::ST_DONE;
                    n_state = (i_func == ent_pkg::FN_CHANGE || i_func == ent_pkg::FN_FIRE ||
                               i_func == ent_pkg::FN_COLLECT) ? ent_pkg::S_SCAN
                                                              : ent_pkg::S_FIN;
                end
            end
            ent_pkg::S_SCAN: begin
                case (r_func)
                    ent_pkg::FN_CHANGE: begin
                        if (at_end || key_hit) begin
                            n_state = ent_pkg::S_FIN;
                            if (is_del) begin
                                if (!at_end) begin
                                    n_state = ent_pkg::S_SHIFT;
                                end
                            end else if (is_trig) begin
                                if (!at_end) begin
                                    wr_en       = 1'b1;
                                    wr_ent.pend = 1'b1;
                                    wr_ent.data = r_data;
                                    if (r_user != 64'h0) begin
                                        wr_ent.user = r_user;
                                    end
                                end
                            end else if (!at_end ||
                                         r_cnt != ent_pkg::CNT_W'(ent_pkg::TABLE_DEPTH)) begin
                                wr_en  = 1'b1;
                                wr_ent = '{ident: r_ident, filter: r_filter, flags: r_flags,
                                           fflags: r_fflags, data: r_data, user: r_user,
                                           pend: 1'b0};
                                if (at_end) begin
                                    n_cnt = r_cnt + ent_pkg::CNT_W'(1);
                                end
                            end else begin
                                n_stat = ent_pkg::ST_FULL;
                            end
                        end else begin
                            n_idx = r_idx + ent_pkg::CNT_W'(1);
                        end
                    end
                    ent_pkg::FN_FIRE: begin
                        if (at_end) begin
                            n_state = ent_pkg::S_FIN;
                        end else begin
                            if (fire_hit) begin
                                wr_en       = 1'b1;
                                wr_ent.pend = 1'b1;
                                wr_ent.data = r_data;
                            end
                            n_idx = r_idx + ent_pkg::CNT_W'(1);
                        end
                    end
                    default: begin
                        // collect: hold one found entry, push it when the next appears or the walk ends
                        if (at_end || r_n == r_lim) begin
                            n_state = ent_pkg::S_FIN;
                        end else if (rd.pend) begin
                            if (!r_have || out_free) begin
                                push        = r_have;
                                push_ev     = 1'b1;
                                n_hold      = rd;
                                n_have      = 1'b1;
                                n_n         = r_n + ent_pkg::LIM_W'(1);
                                wr_en       = 1'b1;
                                wr_ent.pend = 1'b0;
                                n_idx       = r_idx + ent_pkg::CNT_W'(1);
                            end
                        end else begin
                            n_idx = r_idx + ent_pkg::CNT_W'(1);
                        end
                    end
                endcase
            end
            ent_pkg::S_SHIFT: begin
                if (r_idx + ent_pkg::CNT_W'(1) < r_cnt) begin
                    wr_en = 1'b1;
                    n_idx = r_idx + ent_pkg::CNT_W'(1);
                end else begin
                    n_cnt   = r_cnt - ent_pkg::CNT_W'(1);
                    n_state = ent_pkg::S_FIN;
                end
            end
            ent_pkg::S_FIN: begin
                push      = 1'b1;
                push_last = 1'b1;
                push_stat = r_have ? ent_pkg::ST_DONE : r_stat;
                if (out_free) begin
                    n_have  = 1'b0;
                    n_state = ent_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ent_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ent_pkg::S_IDLE;
            r_cnt    <= '0;
            r_idx    <= '0;
            r_n      <= '0;
            r_stat   <= ent_pkg::ST_DONE;
            r_have   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_idx   <= n_idx;
            r_n     <= n_n;
            r_stat  <= n_stat;
            r_have  <= n_have;
            if (push && out_free) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_hold <= n_hold;
        if (accept) begin
            r_func   <= i_func;
            r_ident  <= i_event_ident;
            r_any    <= i_any_ident;
            r_filter <= i_event_filter;
            r_flags  <= i_event_flags;
            r_fflags <= i_event_fflags;
            r_data   <= i_event_data;
            r_user   <= i_user_word;
            r_lim    <= (i_max_out > ent_pkg::LIM_W'(ent_pkg::MAX_RESULTS)) ?
                        ent_pkg::LIM_W'(ent_pkg::MAX_RESULTS) : i_max_out;
        end
        if (push && out_free) begin
            r_ostat <= push_stat;
            r_olast <= push_last;
            r_oev   <= push_ev;
            r_oent  <= push_ev ? r_hold : '0;
        end
        if (wr_en) begin
            r_tab[r_idx[ent_pkg::IDX_W-1:0]] <= wr_ent;
        end
    end

    assign o_out_valid     = r_ovalid;
    assign o_status        = r_ostat;
    assign o_event_valid   = r_oev;
    assign o_last          = r_olast;
    assign o_out_ident     = r_oent.ident;
    assign o_out_filter    = r_oent.filter;
    assign o_out_flags     = r_oent.flags;
    assign o_out_fflags    = r_oent.fflags;
    assign o_out_data      = r_oent.data;
    assign o_out_user_word = r_oent.user;

endmodule

### hdl/ent_checker.sv
// Port-level checks for the event note table, bound to the top level.
module ent_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  o_status,
    input logic        o_event_valid,
    input logic [63:0] o_out_ident,
    input logic        o_last
);

    // one item at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("ready stayed high after accept");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    a_no_event_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_event_valid |-> o_out_ident == 64'h0 && o_last)
        else $error("non-event result not final or not zeroed");

    a_err_no_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ent_pkg::ST_DONE |-> !o_event_valid)
        else $error("error status carries an event");

endmodule

bind event_note_table ent_checker u_ent_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_status      (o_status),
    .o_event_valid (o_event_valid),
    .o_out_ident   (o_out_ident),
    .o_last        (o_last)
);

### test/event_note_table_chk.sv
// Result checker for the event note table: predicts each item's results and compares.
module event_note_table_chk (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [15:0]  i_cfg_mask,
    input  logic         i_in_valid,
    input  logic         i_in_ready,
    input  logic [1:0]   i_func,
    input  logic [63:0]  i_event_ident,
    input  logic         i_any_ident,
    input  logic [15:0]  i_event_filter,
    input  logic [15:0]  i_event_flags,
    input  logic [31:0]  i_event_fflags,
    input  logic [63:0]  i_event_data,
    input  logic [63:0]  i_user_word,
    input  logic [4:0]   i_max_out,
    input  logic         i_out_valid,
    input  logic         i_out_ready,
    input  logic [1:0]   i_status,
    input  logic         i_event_valid,
    input  logic [63:0]  i_out_ident,
    input  logic [15:0]  i_out_filter,
    input  logic [15:0]  i_out_flags,
    input  logic [31:0]  i_out_fflags,
    input  logic [63:0]  i_out_data,
    input  logic [63:0]  i_out_user_word,
    input  logic         i_last,
    output int           o_fail_count,
    output int           o_pending_count
);

    typedef struct packed {
        logic [1:0]  status;
        logic        valid;
        logic [63:0] ident;
        logic [15:0] filter;
        logic [15:0] flags;
        logic [31:0] fflags;
        logic [63:0] data;
        logic [63:0] user;
        logic        last;
    } t_note;

    t_note           due_notes[$];
    ent_pkg::t_entry tbl[ent_pkg::TABLE_DEPTH];
    int              n_used;
    logic [15:0]     del_mask;

    assign o_pending_count = due_notes.size();

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        o_fail_count++;
    endtask

    function automatic int find_key(input logic [63:0] id, input logic [15:0] flt);
        for (int i = 0; i < n_used; i++)
            if (tbl[i].ident == id && tbl[i].filter == flt) return i;
        return n_used;
    endfunction

    task automatic add_note(input t_note r);
        due_notes.insert(due_notes.size(), r);
    endtask

    task automatic predict_item();
        t_note r;
        int    idx, lim, got;
        r = '0;
        r.last = 1'b1;
        if (i_func == ent_pkg::FN_CHANGE) begin
            idx = find_key(i_event_ident, i_event_filter);
            if ((i_event_flags & del_mask) != 16'h0) begin
                if (idx < n_used) begin
                    for (int j = idx; j + 1 < n_used; j++) tbl[j] = tbl[j + 1];
                    n_used--;
                end
            end else if (i_event_filter == ent_pkg::USER_FILTER &&
                         i_event_fflags[ent_pkg::USER_TRIG_BIT]) begin
                if (idx < n_used) begin
                    tbl[idx].pend = 1'b1;
                    tbl[idx].data = i_event_data;
                    if (i_user_word != 64'h0) tbl[idx].user = i_user_word;
                end
            end else if (idx >= n_used && n_used >= ent_pkg::TABLE_DEPTH) begin
                r.status = ent_pkg::ST_FULL;
            end else begin
                if (idx >= n_used) n_used++;
                tbl[idx] = '{i_event_ident, i_event_filter, i_event_flags, i_event_fflags,
                             i_event_data, i_user_word, 1'b0};
            end
            add_note(r);
        end else if (i_func == ent_pkg::FN_FIRE) begin
            for (int i = 0; i < n_used; i++)
                if ((i_event_filter == 16'h0 || tbl[i].filter == i_event_filter) &&
                    (i_any_ident || tbl[i].ident == i_event_ident)) begin
                    tbl[i].pend = 1'b1;
                    tbl[i].data = i_event_data;
                end
            add_note(r);
        end else if (i_func == ent_pkg::FN_COLLECT) begin
            lim = (i_max_out > ent_pkg::MAX_RESULTS) ? ent_pkg::MAX_RESULTS : int'(i_max_out);
            got = 0;
            for (int i = 0; i < n_used && got < lim; i++)
                if (tbl[i].pend) begin
                    if (got > 0) due_notes[$].last = 1'b0;
                    r = '0;
                    r.valid = 1'b1;
                    r.last = 1'b1;
                    r.ident = tbl[i].ident;
                    r.filter = tbl[i].filter;
                    r.flags = tbl[i].flags;
                    r.fflags = tbl[i].fflags;
                    r.data = tbl[i].data;
                    r.user = tbl[i].user;
                    tbl[i].pend = 1'b0;
                    add_note(r);
                    got++;
                end
            if (got == 0) begin
                r.status = ent_pkg::ST_EMPTY;
                add_note(r);
            end
        end else begin
            add_note(r);
        end
    endtask

    task automatic check_result();
        t_note w;
        if (due_notes.size() == 0) begin
            report("unexpected result item", 64'h0, 64'h0);
            return;
        end
        w = due_notes.pop_front();
        if (i_status != w.status) report("status", i_status, w.status);
        if (i_event_valid != w.valid) report("event_valid", i_event_valid, w.valid);
        if (i_out_ident != w.ident) report("ident", i_out_ident, w.ident);
        if (i_out_filter != w.filter) report("filter", i_out_filter, w.filter);
        if (i_out_flags != w.flags) report("flags", i_out_flags, w.flags);
        if (i_out_fflags != w.fflags) report("fflags", i_out_fflags, w.fflags);
        if (i_out_data != w.data) report("data", i_out_data, w.data);
        if (i_out_user_word != w.user) report("user", i_out_user_word, w.user);
        if (i_last != w.last) report("last", i_last, w.last);
    endtask

    initial o_fail_count = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            n_used = 0;
            del_mask = ent_pkg::DEL_MASK_RST;
        end else begin
            if (i_cfg_we) del_mask = i_cfg_mask;
            if (i_out_valid && i_out_ready) check_result();
            if (i_in_valid && i_in_ready) predict_item();
        end
    end

endmodule

### test/event_note_table_tb.sv
// Testbench top for the event note table: stimulus, config writes and verdict.
module event_note_table_tb;

    localparam logic [31:0] TRIG_FF = 32'h0000_0001 << ent_pkg::USER_TRIG_BIT;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;
    logic         i_in_valid = 1'b0;
    logic         o_in_ready;
    logic [1:0]   i_func = ent_pkg::FN_CHANGE;
    logic [63:0]  i_event_ident = '0;
    logic         i_any_ident = 1'b0;
    logic [15:0]  i_event_filter = '0;
    logic [15:0]  i_event_flags = '0;
    logic [31:0]  i_event_fflags = '0;
    logic [63:0]  i_event_data = '0;
    logic [63:0]  i_user_word = '0;
    logic [4:0]   i_max_out = '0;
    logic         o_out_valid;
    logic         i_out_ready = 1'b0;
    logic [1:0]   o_status;
    logic         o_event_valid;
    logic [63:0]  o_out_ident;
    logic [15:0]  o_out_filter;
    logic [15:0]  o_out_flags;
    logic [31:0]  o_out_fflags;
    logic [63:0]  o_out_data;
    logic [63:0]  o_out_user_word;
    logic         o_last;

    int fail_count, pending_count;
    int idle_cycles;
    bit hold_out;      // long receiver hold-off request
    bit stim_done;

    // Small key pools so changes, fires and deletes hit existing entries often.
    logic [63:0] id_pool[4];
    logic [15:0] flt_pool[4];
    logic [15:0] del_mask_cur;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    event_note_table dut (.*);

    event_note_table_chk chk (
        .i_clk, .i_rst_n,
        .i_cfg_we(psel && penable && pwrite && pready &&
                  paddr == 3'(4 * ent_pkg::REG_DEL_MASK)),
        .i_cfg_mask(pwdata[15:0]),
        .i_in_valid, .i_in_ready(o_in_ready),
        .i_func, .i_event_ident, .i_any_ident, .i_event_filter, .i_event_flags,
        .i_event_fflags, .i_event_data, .i_user_word, .i_max_out,
        .i_out_valid(o_out_valid), .i_out_ready,
        .i_status(o_status), .i_event_valid(o_event_valid),
        .i_out_ident(o_out_ident), .i_out_filter(o_out_filter),
        .i_out_flags(o_out_flags), .i_out_fflags(o_out_fflags),
        .i_out_data(o_out_data), .i_out_user_word(o_out_user_word),
        .i_last(o_last),
        .o_fail_count(fail_count), .o_pending_count(pending_count)
    );

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Receiver: random stalls, plus the long hold-off when asked.
    initial begin
        int g;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_out) begin
                i_out_ready <= 1'b0;
                for (int k = 0; k < 300; k++) @(negedge i_clk);
                hold_out = 1'b0;
            end
            g = gap_len();
            if (g == 0) i_out_ready <= 1'b1;
            else begin
                i_out_ready <= 1'b0;
                repeat (g - 1) @(negedge i_clk);
            end
        end
    end

    // Watchdog: cycles with no handshake on either channel.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000) begin
            $display("event_note_table_tb failed");
            $finish;
        end
    end

    task automatic apb_write(input logic [15:0] val);
        @(negedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= 3'(4 * ent_pkg::REG_DEL_MASK);
        pwdata <= {16'h0, val};
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        del_mask_cur = val;
    endtask

    // Offer one item and hold it until accepted.
    task automatic send(input logic [1:0] fn, input logic [63:0] id, input logic any,
                        input logic [15:0] flt, input logic [15:0] flg,
                        input logic [31:0] ff, input logic [63:0] dat,
                        input logic [63:0] usr, input logic [4:0] mo);
        i_func <= fn; i_event_ident <= id; i_any_ident <= any; i_event_filter <= flt;
        i_event_flags <= flg; i_event_fflags <= ff; i_event_data <= dat;
        i_user_word <= usr; i_max_out <= mo; i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    task automatic lower_valid(input int g);
        if (g > 0) begin
            i_in_valid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
    endtask

    task automatic drain();
        lower_valid(1);
        while (pending_count != 0) @(negedge i_clk);
    endtask

    function automatic logic [63:0] r64();
        return {$urandom, $urandom};
    endfunction

    // Random item biased toward the key pool; flags avoid delete except on purpose.
    task automatic random_item();
        int sel, k;
        logic [15:0] flg, flt;
        logic [31:0] ff;
        logic [63:0] id;
        sel = $urandom_range(0, 99);
        k = $urandom_range(0, 3);
        id = ($urandom_range(0, 9) == 0) ? r64() : id_pool[k];
        flt = ($urandom_range(0, 9) == 0) ? 16'($urandom) : flt_pool[$urandom_range(0, 3)];
        flg = 16'($urandom) & ~del_mask_cur;
        ff = $urandom;
        if (sel < 35) begin
            send(ent_pkg::FN_CHANGE, id, 1'b0, flt, flg, ff & ~TRIG_FF, r64(), r64(), 5'd0);
        end else if (sel < 45) begin
            send(ent_pkg::FN_CHANGE, id, 1'b0, flt, 16'($urandom) | del_mask_cur, ff,
                 r64(), r64(), 5'd0);
        end else if (sel < 55) begin
            send(ent_pkg::FN_CHANGE, id, 1'b0, ent_pkg::USER_FILTER, flg, ff | TRIG_FF,
                 r64(), ($urandom_range(0, 2) == 0) ? 64'h0 : r64(), 5'd0);
        end else if (sel < 75) begin
            send(ent_pkg::FN_FIRE, id, 1'($urandom_range(0, 3) == 0),
                 ($urandom_range(0, 3) == 0) ? 16'h0 : flt, flg, ff, r64(), r64(), 5'd0);
        end else if (sel < 97) begin
            send(ent_pkg::FN_COLLECT, r64(), 1'($urandom), 16'($urandom), 16'($urandom),
                 $urandom, r64(), r64(), 5'($urandom));
        end else begin
            send(ent_pkg::FN_UNUSED, r64(), 1'($urandom), 16'($urandom), 16'($urandom),
                 $urandom, r64(), r64(), 5'($urandom));
        end
    endtask

    initial begin
        logic [15:0] masks[4];
        masks = '{16'h0002, 16'hFFFF, 16'h8000, 16'h0000};
        for (int k = 0; k < 4; k++) begin
            id_pool[k] = r64();
            flt_pool[k] = 16'($urandom);
        end
        id_pool[0] = 64'h0; id_pool[1] = '1;
        flt_pool[0] = 16'h8000; flt_pool[1] = 16'h7FFF; flt_pool[2] = ent_pkg::USER_FILTER;
        del_mask_cur = ent_pkg::DEL_MASK_RST;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: fill past full, user trigger, fires, collects, delete, bad func.
        for (int k = 0; k < 17; k++)
            send(ent_pkg::FN_CHANGE, 64'(k), 1'b0, (k == 0) ? ent_pkg::USER_FILTER : 16'(k),
                 16'h0, 32'h0, 64'(-k), '1, 5'd0);
        send(ent_pkg::FN_CHANGE, 64'h0, 1'b0, ent_pkg::USER_FILTER, 16'hFFFD, TRIG_FF,
             64'h8000_0000_0000_0000, 64'h0, 5'd0);
        send(ent_pkg::FN_COLLECT, '1, 1'b1, '1, '1, '1, '1, '1, 5'd31);
        send(ent_pkg::FN_FIRE, '1, 1'b1, 16'h0, '1, '1, 64'h7FFF_FFFF_FFFF_FFFF, '1, '1);
        send(ent_pkg::FN_COLLECT, '0, 1'b0, '0, '0, '0, '0, '0, 5'd0);
        send(ent_pkg::FN_COLLECT, '0, 1'b0, '0, '0, '0, '0, '0, 5'd3);
        send(ent_pkg::FN_COLLECT, '0, 1'b0, '0, '0, '0, '0, '0, 5'd31);
        send(ent_pkg::FN_FIRE, 64'd5, 1'b0, 16'd5, '0, '0, 64'd1, '0, 5'd0);
        send(ent_pkg::FN_CHANGE, 64'd3, 1'b0, 16'd3, 16'h0002, '0, '0, '0, 5'd0);
        send(ent_pkg::FN_COLLECT, '0, 1'b0, '0, '0, '0, '0, '0, 5'd16);
        send(ent_pkg::FN_UNUSED, '1, 1'b1, '1, '1, '1, '1, '1, '1);
        drain();

        // Random phases, one per delete-mask setting.
        for (int ph = 0; ph < 4; ph++) begin
            apb_write(masks[ph]);
            for (int n = 0; n < 120; n++) begin
                if (ph == 1 && n == 30) hold_out = 1'b1;   // receiver goes quiet
                if (ph == 2 && n == 60) drain();           // sender waits out all results
                random_item();
                if ($urandom_range(0, 4) == 0) lower_valid(0);
                else lower_valid(gap_len());
            end
            drain();
        end
        apb_write(ent_pkg::DEL_MASK_RST);
        drain();

        if (fail_count == 0 && pending_count == 0)
            $display("event_note_table_tb passed");
        else
            $display("event_note_table_tb failed");
        $finish;
    end

endmodule

### event_note_table.f
hdl/ent_pkg.sv
hdl/event_note_table.sv
hdl/ent_checker.sv
test/event_note_table_chk.sv
test/event_note_table_tb.sv
